>>> design/ptrb_pkg.sv
// shared types and constants of the page table range builder
package ptrb_pkg;

    localparam int POOL_TABLES_DEF = 8;
    localparam int TABLE_ENTRIES   = 512;
    localparam int SLOT_W          = 9;
    localparam int VPN_W           = 36;
    localparam int PPN_W           = 44;
    localparam int PTE_W           = 64;
    localparam int CFG_W           = 44;

    typedef enum logic [0:0] {
        CFG_LEVELS    = 1'b0,
        CFG_POOL_BASE = 1'b1
    } ptrb_cfg_idx_t;

    typedef enum logic [1:0] {
        ST_MAP_DONE  = 2'd0,
        ST_STOPPED   = 2'd1,
        ST_READ_DONE = 2'd2
    } ptrb_status_t;

    typedef enum logic [0:0] {
        ACT_MAP  = 1'b0,
        ACT_READ = 1'b1
    } ptrb_action_t;

    typedef struct packed {
        logic        action;
        logic [35:0] virt_start_page;
        logic [15:0] page_count;
        logic [43:0] phys_start_page;
        logic        writeable;
        logic [2:0]  read_table;
        logic [8:0]  read_slot;
    } ptrb_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] pages_written;
        logic [15:0] pages_skipped;
        logic [3:0]  tables_used;
        logic [63:0] read_entry;
        logic signed [3:0] read_parent;
    } ptrb_out_t;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic walk_rd;
        logic walk_chk;
        logic leaf_rd;
        logic leaf_chk;
        logic read_rd;
        logic finish;
    } ptrb_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_read;
        logic zero_count;
        logic walk_fail;
        logic last_lvl;
        logic last_page;
        logic out_free;
    } ptrb_stat_t;

endpackage

>>> design/ptrb_dpath.sv
// datapath: item registers, table store, parent table, counters and result register
module ptrb_dpath import ptrb_pkg::*; #(
    parameter int PoolTables = POOL_TABLES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  ptrb_cmd_t     cmd,
    output ptrb_stat_t    stat,
    input  ptrb_in_t      s_data,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    output logic          m_valid,
    input  logic          m_ready,
    output ptrb_out_t     m_data
);

    localparam int TW    = (PoolTables > 1) ? $clog2(PoolTables) : 1;
    localparam int CW    = $clog2(PoolTables + 1);
    localparam int Depth = PoolTables * TABLE_ENTRIES;
    localparam int AW    = TW + SLOT_W;

    logic [2:0]       levels_reg;
    logic [PPN_W-1:0] base_reg;

    ptrb_in_t         item_reg;
    logic [VPN_W-1:0] vpn_reg;
    logic [PPN_W-1:0] ppn_reg;
    logic [15:0]      k_reg;
    logic [15:0]      written_reg;
    logic [15:0]      skipped_reg;
    logic             fail_reg;
    logic [1:0]       lvl_reg;
    logic [TW-1:0]    tbl_reg;
    logic [CW-1:0]    count_reg;
    logic [AW-1:0]    clr_addr_reg;
    logic [AW-1:0]    addr_reg;
    logic [PTE_W-1:0] rd_data_reg;
    logic             parent_valid_reg [PoolTables];
    logic [TW-1:0]    parent_idx_reg [PoolTables];
    logic [PTE_W-1:0] mem [Depth];
    logic             m_valid_reg;
    ptrb_out_t        m_data_reg;

    logic [1:0]       top_lvl;
    logic [SLOT_W-1:0] walk_slot;
    logic [AW-1:0]    rd_addr;
    logic             rd_en;
    logic             mem_we;
    logic [AW-1:0]    wr_addr;
    logic [PTE_W-1:0] wr_data;
    logic             entry_v;
    logic [PPN_W-1:0] ptr_off;
    logic             ptr_bad;
    logic             pool_full;
    logic             do_alloc;
    logic [TW-1:0]    fresh;
    logic [TW-1:0]    rd_tbl;
    logic             rd_in_pool;
    ptrb_out_t        result;

    assign top_lvl = (levels_reg >= 3'd4) ? 2'd3 : 2'd2;

    always_comb begin
        case (lvl_reg)
            2'd3:    walk_slot = vpn_reg[35:27];
            2'd2:    walk_slot = vpn_reg[26:18];
            default: walk_slot = vpn_reg[17:9];
        endcase
    end

    assign rd_tbl     = TW'(item_reg.read_table);
    assign rd_in_pool = int'(item_reg.read_table) < PoolTables;

    always_comb begin
        rd_addr = {tbl_reg, walk_slot};
        if (cmd.leaf_rd) begin
            rd_addr = {tbl_reg, vpn_reg[SLOT_W-1:0]};
        end else if (cmd.read_rd) begin
            rd_addr = {rd_tbl, item_reg.read_slot};
        end
    end
    assign rd_en = cmd.walk_rd | cmd.leaf_rd | cmd.read_rd;

    assign entry_v   = rd_data_reg[0];
    assign ptr_off   = rd_data_reg[PPN_W+9:10] - base_reg;
    assign ptr_bad   = entry_v && (ptr_off >= PPN_W'(count_reg));
    assign pool_full = count_reg == CW'(PoolTables);
    assign do_alloc  = cmd.walk_chk && !entry_v && !pool_full;
    assign fresh     = TW'(count_reg);

    always_comb begin
        mem_we  = 1'b0;
        wr_addr = addr_reg;
        wr_data = '0;
        if (cmd.clr_wr) begin
            mem_we  = 1'b1;
            wr_addr = clr_addr_reg;
        end else if (do_alloc) begin
            mem_we  = 1'b1;
            wr_data = {10'd0, base_reg + PPN_W'(count_reg), 9'd0, 1'b1};
        end else if (cmd.leaf_chk && !entry_v) begin
            mem_we  = 1'b1;
            wr_data = {10'd0, ppn_reg, 6'd0, 1'b1, item_reg.writeable, 1'b1, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            addr_reg    <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg <= 3'd3;
            base_reg   <= '0;
        end else if (cfg_we) begin
            unique case (ptrb_cfg_idx_t'(cfg_index))
                CFG_LEVELS:    levels_reg <= cfg_wdata[2:0];
                CFG_POOL_BASE: base_reg   <= cfg_wdata[PPN_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            count_reg    <= CW'(1);
            for (int i = 0; i < PoolTables; i++) begin
                parent_valid_reg[i] <= 1'b0;
            end
        end else begin
            if (cmd.clr_wr) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (do_alloc) begin
                count_reg                <= count_reg + CW'(1);
                parent_valid_reg[fresh]  <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_alloc) begin
            parent_idx_reg[fresh] <= tbl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg    <= s_data;
            vpn_reg     <= s_data.virt_start_page;
            ppn_reg     <= s_data.phys_start_page;
            k_reg       <= '0;
            written_reg <= '0;
            skipped_reg <= '0;
            fail_reg    <= 1'b0;
            lvl_reg     <= top_lvl;
            tbl_reg     <= '0;
        end else if (cmd.walk_chk) begin
            if (entry_v) begin
                if (ptr_bad) begin
                    fail_reg <= 1'b1;
                end else begin
                    tbl_reg <= TW'(ptr_off);
                end
            end else if (pool_full) begin
                fail_reg <= 1'b1;
            end else begin
                tbl_reg <= fresh;
            end
            lvl_reg <= lvl_reg - 2'd1;
        end else if (cmd.leaf_chk) begin
            if (entry_v) begin
                skipped_reg <= skipped_reg + 16'd1;
            end else begin
                written_reg <= written_reg + 16'd1;
            end
            k_reg   <= k_reg + 16'd1;
            vpn_reg <= vpn_reg + VPN_W'(1);
            ppn_reg <= ppn_reg + PPN_W'(1);
            lvl_reg <= top_lvl;
            tbl_reg <= '0;
        end
    end

    always_comb begin
        result               = '0;
        result.tables_used   = 4'(count_reg);
        if (item_reg.action == ACT_READ) begin
            result.status      = ST_READ_DONE;
            result.read_parent = 4'hF;
            if (rd_in_pool) begin
                result.read_entry = rd_data_reg;
                if (parent_valid_reg[rd_tbl]) begin
                    result.read_parent = 4'(parent_idx_reg[rd_tbl]);
                end
            end
        end else begin
            result.status        = fail_reg ? ST_STOPPED : ST_MAP_DONE;
            result.pages_written = written_reg;
            result.pages_skipped = skipped_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign stat.clr_last   = clr_addr_reg == AW'(Depth - 1);
    assign stat.is_read    = s_data.action == ACT_READ;
    assign stat.zero_count = s_data.page_count == 16'd0;
    assign stat.walk_fail  = entry_v ? ptr_bad : pool_full;
    assign stat.last_lvl   = lvl_reg == 2'd1;
    assign stat.last_page  = k_reg == (item_reg.page_count - 16'd1);
    assign stat.out_free   = !m_valid_reg || m_ready;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CW'(1)) && (count_reg <= CW'(PoolTables)))
        else $error("table count out of range");

    a_root_no_parent: assert property (@(posedge aclk) disable iff (!aresetn)
        !parent_valid_reg[0])
        else $error("root table got a parent");

    a_alloc_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        do_alloc |=> count_reg == $past(count_reg) + CW'(1))
        else $error("allocation did not advance table count");

    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before taken");

endmodule

>>> design/ptrb_ctrl.sv
// controller state machine: clear pass, table walk, leaf update, entry read and result hand-off
module ptrb_ctrl import ptrb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  ptrb_stat_t stat,
    output ptrb_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_WALK_RD  = 8'b0000_0100,
        S_WALK_CHK = 8'b0000_1000,
        S_LEAF_RD  = 8'b0001_0000,
        S_LEAF_CHK = 8'b0010_0000,
        S_READ_RD  = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (stat.is_read) begin
                        state_next = S_READ_RD;
                    end else if (stat.zero_count) begin
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_WALK_RD;
                    end
                end
            end
            S_WALK_RD: begin
                cmd.walk_rd = 1'b1;
                state_next  = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                cmd.walk_chk = 1'b1;
                if (stat.walk_fail) begin
                    state_next = S_FINISH;
                end else if (stat.last_lvl) begin
                    state_next = S_LEAF_RD;
                end else begin
                    state_next = S_WALK_RD;
                end
            end
            S_LEAF_RD: begin
                cmd.leaf_rd = 1'b1;
                state_next  = S_LEAF_CHK;
            end
            S_LEAF_CHK: begin
                cmd.leaf_chk = 1'b1;
                state_next   = stat.last_page ? S_FINISH : S_WALK_RD;
            end
            S_READ_RD: begin
                cmd.read_rd = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command");

    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_ready)
        else $error("item accepted during clear pass");

    a_walk_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_rd |=> cmd.walk_chk)
        else $error("walk read not followed by check");

endmodule

>>> design/page_table_range_builder.sv
// top level of the page table range builder
//
//  channel  | ports                               | role
//  ---------+-------------------------------------+-------------------------------
//  s_       | s_valid, s_ready, s_data            | map or read item in
//  m_       | m_valid, m_ready, m_data            | one result item per input item
//  cfg_     | cfg_we, cfg_index, cfg_wdata        | levels and pool base registers
//
//  after reset a clear pass zeroes the table store, all POOL_TABLES*512 entries, no items taken
//  read item: loaded into the item register, one store read, then the result register
//  map item: each page walks every table level, 3, or 4 when levels is 4 or more; each level costs
//  one store read and one check, the single store read port sets the pace
//  a full result register holds the controller until m_ready
module page_table_range_builder import ptrb_pkg::*; #(
    parameter int POOL_TABLES = POOL_TABLES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ptrb_in_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output ptrb_out_t        m_data,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    ptrb_cmd_t  cmd;
    ptrb_stat_t stat;

    ptrb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ptrb_dpath #(
        .PoolTables (POOL_TABLES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
